/* rtl/smx_pkg.sv */
// Package: shared widths, constants, command/status types and the exp table.
package smx_pkg;
  localparam int SampleW = 16;
  localparam int ExpW = 17;
  localparam int SumW = 23;
  localparam int ProbW = 16;
  localparam int MaxLenDefault = 64;
  localparam int Log2eQ16 = 94548;
  localparam int RecipW = 40;

  typedef struct packed {
    logic store_we;
    logic exp_step;
    logic exp_wr;
    logic rcp_start;
    logic norm_mul;
    logic out_load;
    logic clear;
  } smx_cmd_t;

  typedef struct packed {
    logic rcp_done;
  } smx_sts_t;

  function automatic logic [ExpW-1:0] pow2_tab(input logic [4:0] i);
    logic [ExpW-1:0] v;
    case (i)
      5'd0: v = 17'd65536;
      5'd1: v = 17'd62757;
      5'd2: v = 17'd60097;
      5'd3: v = 17'd57549;
      5'd4: v = 17'd55109;
      5'd5: v = 17'd52773;
      5'd6: v = 17'd50535;
      5'd7: v = 17'd48393;
      5'd8: v = 17'd46341;
      5'd9: v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

/* rtl/smx_if.sv */
// Interfaces: valid/ready channels for samples and results.
interface smx_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] sample;
  logic is_last;
  modport source (output valid, sample, is_last, input ready);
  modport sink (input valid, sample, is_last, output ready);
endinterface

interface smx_out_if;
  logic valid;
  logic ready;
  logic [15:0] probability;
  logic is_last_res;
  logic overflow;
  modport source (output valid, probability, is_last_res, overflow, input ready);
  modport sink (input valid, probability, is_last_res, overflow, output ready);
endinterface

/* rtl/softmax_normalizer.sv */
// Top level: softmax over one vector, controller plus datapath.
//  channel | dir | payload
//  in_     | in  | sample[15:0] signed Q8.8, is_last
//  out_    | out | probability[15:0] Q0.16, is_last_res, overflow
// Load takes one sample per cycle. The exp pass reads, multiplies and writes
// each element in turn, then the bit-serial reciprocal runs, then the normalize
// pass reads, multiplies and outputs each element (stalling while out_ready is low).
// rst_n is synchronous; no samples are taken during the exp or normalize pass.
module softmax_normalizer #(
  parameter int MAX_LEN = smx_pkg::MaxLenDefault
) (
  input logic clk,
  input logic rst_n,
  smx_in_if.sink in_ch,
  smx_out_if.source out_ch
);
  import smx_pkg::*;
  localparam int IdxW = $clog2(MAX_LEN);

  smx_cmd_t cmd;
  smx_sts_t sts;
  logic [IdxW-1:0] wr_idx, rd_idx;
  logic last_flag, trunc_flag;

  smx_ctrl #(.MAX_LEN(MAX_LEN), .IdxW(IdxW)) u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_is_last(in_ch.is_last), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts, .wr_idx, .rd_idx, .last_flag, .trunc_flag
  );

  smx_datapath #(.MAX_LEN(MAX_LEN), .IdxW(IdxW)) u_dp (
    .clk, .rst_n, .cmd, .sts, .wr_idx, .rd_idx,
    .in_sample(in_ch.sample), .last_flag, .trunc_flag,
    .probability(out_ch.probability), .is_last_res(out_ch.is_last_res),
    .overflow(out_ch.overflow)
  );
endmodule

/* rtl/smx_datapath.sv */
// Datapath: sample and exp memories, max tracking, exp unit, sum, reciprocal, scaling.
module smx_datapath #(
  parameter int MAX_LEN = smx_pkg::MaxLenDefault,
  parameter int IdxW = $clog2(MAX_LEN)
) (
  input  logic clk,
  input  logic rst_n,
  input  smx_pkg::smx_cmd_t cmd,
  output smx_pkg::smx_sts_t sts,
  input  logic [IdxW-1:0] wr_idx,
  input  logic [IdxW-1:0] rd_idx,
  input  logic signed [15:0] in_sample,
  input  logic last_flag,
  input  logic trunc_flag,
  output logic [15:0] probability,
  output logic is_last_res,
  output logic overflow
);
  import smx_pkg::*;

  logic [SampleW-1:0] sample_mem [MAX_LEN];
  logic [ExpW-1:0] exp_mem [MAX_LEN];
  logic signed [SampleW-1:0] max_r;
  logic [SampleW-1:0] smp_rd_r;
  logic [33:0] y_r;
  logic [ExpW-1:0] exp_val;
  logic [SumW-1:0] sum_r;
  logic [ExpW-1:0] exp_rd_r;
  logic [ProbW-1:0] prob_r;
  logic last_r, ovf_r;
  logic [63:0] prod_r;

  // Reciprocal unit: floor(2^RecipW / sum), one quotient bit per cycle.
  logic [RecipW-1:0] q_r;
  logic [SumW:0] rem_r;
  logic [5:0] bit_r;
  logic busy_r;
  logic [SumW:0] rem_sh;

  always_ff @(posedge clk) begin
    if (cmd.store_we) sample_mem[wr_idx] <= in_sample;
    smp_rd_r <= sample_mem[rd_idx];
    exp_rd_r <= exp_mem[rd_idx];
    if (cmd.exp_wr) exp_mem[rd_idx] <= exp_val;
  end

  logic [16:0] delta;
  assign delta = 17'($signed(max_r) - $signed(smp_rd_r));

  always_ff @(posedge clk) begin
    if (cmd.exp_step) y_r <= 34'(delta[15:0]) * 34'(Log2eQ16);
  end

  always_comb begin
    logic [15:0] f;
    logic [ExpW-1:0] hi, lo;
    logic [29:0] t;
    logic [ExpW-1:0] v;
    logic [9:0] k;
    f = y_r[23:8];
    hi = pow2_tab({1'b0, f[15:12]});
    lo = pow2_tab(5'({1'b0, f[15:12]} + 5'd1));
    t = 30'(hi - lo) * 30'(f[11:0]) + 30'd2048;
    v = hi - ExpW'(t >> 12);
    k = y_r[33:24];
    exp_val = (k >= 10'd17) ? '0 : ExpW'(v >> k);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      max_r <= 16'sh8000;
      sum_r <= '0;
    end else begin
      if (cmd.store_we && in_sample > max_r) max_r <= in_sample;
      if (cmd.exp_wr) sum_r <= sum_r + SumW'(exp_val);
    end
  end

  assign rem_sh = {rem_r[SumW-1:0], (bit_r == 6'(RecipW)) ? 1'b1 : 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      bit_r <= '0;
    end else if (cmd.rcp_start) begin
      busy_r <= 1'b1;
      bit_r <= 6'(RecipW);
      rem_r <= '0;
      q_r <= '0;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, sum_r}) begin
        rem_r <= rem_sh - {1'b0, sum_r};
        q_r <= {q_r[RecipW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r <= {q_r[RecipW-2:0], 1'b0};
      end
      if (bit_r == 6'd0) busy_r <= 1'b0;
      bit_r <= bit_r - 6'd1;
    end
  end
  assign sts.rcp_done = !busy_r && !cmd.rcp_start;

  // Multiply estimate e*2^40/sum, then correct by checking against sum.
  logic [63:0] est;
  logic [40:0] ecand, r;
  always_ff @(posedge clk) begin
    if (cmd.norm_mul) prod_r <= 64'(exp_rd_r) * 64'(q_r);
  end
  always_comb begin
    est = prod_r >> 24;
    ecand = 41'(est);
    r = 41'({exp_rd_r, 16'd0}) - 41'(ecand * 41'(sum_r));
    if (r >= 41'(sum_r)) ecand = ecand + 41'd1;
    if (sum_r == '0) ecand = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      prob_r <= (ecand > 41'd65535) ? 16'hFFFF : ecand[15:0];
      last_r <= last_flag;
      ovf_r <= trunc_flag;
    end
  end
  assign probability = prob_r;
  assign is_last_res = last_r;
  assign overflow = ovf_r;
endmodule

/* rtl/smx_ctrl.sv */
// Controller: load, exp pass, reciprocal wait and normalize pass sequencing.
module smx_ctrl #(
  parameter int MAX_LEN = smx_pkg::MaxLenDefault,
  parameter int IdxW = $clog2(MAX_LEN)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_is_last,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output smx_pkg::smx_cmd_t cmd,
  input  smx_pkg::smx_sts_t sts,
  output logic [IdxW-1:0] wr_idx,
  output logic [IdxW-1:0] rd_idx,
  output logic last_flag,
  output logic trunc_flag
);
  import smx_pkg::*;

  localparam logic [2:0] S_LOAD = 3'd0, S_ERD = 3'd1, S_EMUL = 3'd2, S_EWR = 3'd3,
    S_RCP = 3'd4, S_NRD = 3'd5, S_NMUL = 3'd6, S_NOUT = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [IdxW:0] cnt_r;
  logic [IdxW:0] idx_r;
  logic trunc_r, ov_r;
  logic acc, full;
  // The reciprocal unit is started from a registered pulse so rcp_done is low meanwhile.
  logic rcp_go_r;

  assign in_ready = (state_r == S_LOAD);
  assign acc = in_valid && in_ready;
  assign full = (cnt_r == (IdxW+1)'(MAX_LEN));
  assign wr_idx = cnt_r[IdxW-1:0];
  assign rd_idx = idx_r[IdxW-1:0];
  assign out_valid = ov_r;
  assign trunc_flag = trunc_r;
  assign last_flag = (idx_r + 1'b1 == cnt_r);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        cmd.store_we = acc && !full;
        if (acc && in_is_last) state_nxt = S_ERD;
      end
      S_ERD: state_nxt = S_EMUL;
      S_EMUL: begin
        cmd.exp_step = 1'b1;
        state_nxt = S_EWR;
      end
      S_EWR: begin
        cmd.exp_wr = 1'b1;
        if (idx_r + 1'b1 == cnt_r) begin
          state_nxt = S_RCP;
        end else begin
          state_nxt = S_ERD;
        end
      end
      S_RCP: begin
        cmd.rcp_start = rcp_go_r;
        if (sts.rcp_done) state_nxt = S_NRD;
      end
      S_NRD: state_nxt = S_NMUL;
      S_NMUL: begin
        cmd.norm_mul = 1'b1;
        if (!ov_r || out_ready) state_nxt = S_NOUT;
      end
      S_NOUT: begin
        cmd.out_load = 1'b1;
        if (last_flag) begin
          cmd.clear = 1'b1;
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_NRD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r <= '0;
      idx_r <= '0;
      trunc_r <= 1'b0;
      ov_r <= 1'b0;
      rcp_go_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rcp_go_r <= (state_r == S_EWR) && (state_nxt == S_RCP);
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (state_r == S_NOUT) ov_r <= 1'b1;
      if (state_r == S_LOAD && acc) begin
        if (full) trunc_r <= 1'b1;
        else cnt_r <= cnt_r + 1'b1;
        idx_r <= '0;
      end
      if (state_r == S_EWR) idx_r <= (state_nxt == S_RCP) ? '0 : idx_r + 1'b1;
      if (state_r == S_NOUT) begin
        if (last_flag) begin
          idx_r <= '0;
          cnt_r <= '0;
          trunc_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/smx_checker.sv */
// Checker: port-level properties of the softmax block, bound to the top level.
module smx_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] out_probability,
  input logic out_is_last_res
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_probability))
    else $error("result changed while stalled");
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready || out_is_last_res)
    else $error("input taken mid-vector output");
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind softmax_normalizer smx_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_probability(out_ch.probability), .out_is_last_res(out_ch.is_last_res)
);

/* verif/tb_softmax_normalizer.sv */
// Testbench for softmax_normalizer: directed and random vectors checked against a local predictor.
`timescale 1ns / 100ps
module tb_softmax_normalizer;
  import smx_pkg::*;

  localparam int VecMax = 64;
  localparam int StallLimit = 20000;

  typedef struct {
    logic [15:0] probability;
    logic is_last_res;
    logic overflow;
  } prob_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  smx_in_if in_ch ();
  smx_out_if out_ch ();

  softmax_normalizer #(.MAX_LEN(VecMax)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  prob_t expected_probs[$];
  logic signed [15:0] vec_samples[VecMax];
  int vec_count = 0;
  int vec_max = -32768;
  bit vec_trunc = 1'b0;
  int errors = 0;
  int idle_cycles = 0;
  bit sink_busy_ok = 1'b1;

  // Base-2 table of 2^(-i/16) in Q16.
  function automatic int unsigned pow2_at(int i);
    int unsigned t[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                           46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
    return t[i];
  endfunction

  function automatic int unsigned exp_neg(int unsigned d);
    longint unsigned y;
    longint unsigned k;
    int unsigned f, hi, lo, v;
    y = longint'(d & 16'hFFFF) * 94548;
    k = y >> 24;
    f = (y >> 8) & 16'hFFFF;
    hi = pow2_at(f >> 12);
    lo = pow2_at((f >> 12) + 1);
    v = hi - (((hi - lo) * (f & 12'hFFF) + 2048) >> 12);
    if (k >= 17) return 0;
    return (v >> k) & 17'h1FFFF;
  endfunction

  // Accumulates one accepted sample and, on the closing one, queues the vector's probabilities.
  task automatic predict_sample(logic signed [15:0] s, logic last);
    int unsigned e[VecMax];
    int unsigned total;
    longint unsigned p;
    prob_t r;
    if (vec_count < VecMax) begin
      vec_samples[vec_count] = s;
      if (int'(s) > vec_max) vec_max = s;
      vec_count++;
    end else begin
      vec_trunc = 1'b1;
    end
    if (!last) return;
    total = 0;
    for (int i = 0; i < vec_count; i++) begin
      e[i] = exp_neg(vec_max - int'(vec_samples[i]));
      total = (total + e[i]) & 23'h7FFFFF;
    end
    for (int i = 0; i < vec_count; i++) begin
      p = (total == 0) ? 0 : ((longint'(e[i]) << 16) / total);
      if (p > 65535) p = 65535;
      r.probability = p[15:0];
      r.is_last_res = (i + 1 == vec_count);
      r.overflow = vec_trunc;
      expected_probs.push_back(r);
    end
    vec_count = 0;
    vec_max = -32768;
    vec_trunc = 1'b0;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  bit no_gaps = 1'b0;

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(logic signed [15:0] s, logic last);
    int g;
    g = no_gaps ? 0 : gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.is_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_sample(s, last);
    @(negedge clk);
  endtask

  task automatic send_vector(int n, int lo, int hi);
    for (int i = 0; i < n; i++)
      send_sample(16'($urandom_range(hi - lo) + lo), i == n - 1);
  endtask

  // Result side: random back-pressure and in-order comparison.
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (!sink_busy_ok) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 19) == 0);
  end

  always @(posedge clk) begin
    prob_t want;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_probs.size() == 0) begin
          $error("unexpected result transfer: probability %0d", out_ch.probability);
          errors++;
        end else begin
          want = expected_probs.pop_front();
          if (out_ch.probability !== want.probability) begin
            $error("probability: expected %0d actual %0d", want.probability,
                   out_ch.probability);
            errors++;
          end
          if (out_ch.is_last_res !== want.is_last_res) begin
            $error("is_last_res: expected %0d actual %0d", want.is_last_res,
                   out_ch.is_last_res);
            errors++;
          end
          if (out_ch.overflow !== want.overflow) begin
            $error("overflow: expected %0d actual %0d", want.overflow, out_ch.overflow);
            errors++;
          end
        end
      end
      if (idle_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic test_extremes();
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'shFFFF, 1'b1);
    send_sample(-16'sh8000, 1'b1);
    send_sample(16'sh0100, 1'b0);
    send_sample(16'sh0100, 1'b1);
    send_sample(16'sh0005, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sh0200, 1'b0);
    send_sample(16'sh1000, 1'b0);
    send_sample(16'sh1000, 1'b1);
  endtask

  task automatic test_truncation();
    // Overfill the buffer; the dropped samples are larger than any stored one.
    no_gaps = 1'b1;
    for (int i = 0; i < VecMax; i++) send_sample(16'($urandom_range(0, 511)), 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh7000, 1'b1);
    no_gaps = 1'b0;
    // Exactly a full buffer closes without the flag.
    send_vector(VecMax, -1024, 1024);
  endtask

  task automatic test_random();
    int n;
    for (int v = 0; v < 4; v++) begin
      n = $urandom_range(1, 6);
      if ($urandom_range(0, 3) == 0) send_vector(n, -32768, 32767);
      else send_vector(n, -1500, 1500);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.is_last = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_truncation();
    test_random();
    in_ch.valid <= 1'b0;
    while (expected_probs.size() != 0) @(posedge clk);
    sink_busy_ok = 1'b0;
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_probs.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

/* softmax_normalizer.f */
rtl/smx_pkg.sv
rtl/smx_if.sv
rtl/smx_datapath.sv
rtl/smx_ctrl.sv
rtl/softmax_normalizer.sv
rtl/smx_checker.sv
verif/tb_softmax_normalizer.sv
